// ===== hw/rtl/ipt_pkg.sv =====
// Shared types and fixed widths for the inverted page table.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package ipt_pkg;

   localparam int FRAME_W = 5;   // frame_index / frame_out field width
   localparam int OP_W    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_FIND    = 2'd0,
      OP_REQUEST = 2'd1,
      OP_SAVE    = 2'd2,
      OP_MOVE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_RMW_RD,
      ST_RMW_WR
   } state_type;

endpackage

// ===== hw/rtl/ipt_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ipt_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/inverted_page_table_clock.sv =====
// Inverted page table with clock replacement: control, sweep and response logic.
// Depends on ipt_pkg and ipt_ram (frame entry store).
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ------------------------------
//  request   req_op, req_virtual_page, ...           taken when start & !busy
//  response  rsp_found, rsp_frame_out, ...           one-cycle word under rsp_valid
//
// After reset a clearing pass writes every frame entry, with busy high.
// Save, move and request with a free frame: read, then write back, with busy high.
// Find: the scan runs from entry 0, which is always examined, and stops at a match or
// the last occupied entry.
// Request with no free frame: a sweep from the hand to the first entry with use clear;
// the single read port of the entry store paces both scans.
// The response word shows in the cycle after the last busy cycle, when a new word may
// already be taken; the receiver cannot stall.
`timescale 1ns / 1ps

module inverted_page_table_clock #(
   parameter int NUM_FRAMES = 32,
   parameter int VPAGE_BITS = 20,
   parameter int PID_BITS   = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  ipt_pkg::op_type              req_op,
   input  logic [VPAGE_BITS-1:0]        req_virtual_page,
   input  logic [PID_BITS-1:0]          req_process_id,
   input  logic [ipt_pkg::FRAME_W-1:0]  req_frame_index,
   input  logic                         req_new_valid,
   input  logic                         req_new_use,
   input  logic                         req_new_dirty,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic [ipt_pkg::FRAME_W-1:0]  rsp_frame_out,
   output logic                         rsp_write_back,
   output logic [VPAGE_BITS-1:0]        rsp_evicted_page,
   output logic [VPAGE_BITS-1:0]        rsp_entry_page,
   output logic                         rsp_entry_valid
);

   import ipt_pkg::*;

   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam int CNT_W = $clog2(NUM_FRAMES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_FRAMES);

   typedef struct packed {
      logic [VPAGE_BITS-1:0] page;
      logic [PID_BITS-1:0]   pid;
      logic                  valid;
      logic                  use_flag;
      logic                  dirty;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [VPAGE_BITS-1:0]  vpage_ff, vpage_in;
   logic [PID_BITS-1:0]    pid_ff, pid_in;
   logic [FRAME_W-1:0]     fidx_ff, fidx_in;
   logic                   nvalid_ff, nvalid_in;
   logic                   nuse_ff, nuse_in;
   logic                   ndirty_ff, ndirty_in;
   logic                   in_range_ff, in_range_in;
   logic [IDX_W-1:0]       scan_ptr_ff, scan_ptr_in;
   logic [IDX_W-1:0]       chk_ptr_ff, chk_ptr_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [CNT_W-1:0]       alloc_ff, alloc_in;     // frames handed out, lowest first
   logic [IDX_W-1:0]       hand_ff, hand_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [FRAME_W-1:0]     rsp_frame_ff, rsp_frame_in;
   logic                   rsp_wb_ff, rsp_wb_in;
   logic [VPAGE_BITS-1:0]  rsp_evicted_ff, rsp_evicted_in;
   logic [VPAGE_BITS-1:0]  rsp_epage_ff, rsp_epage_in;
   logic                   rsp_evalid_ff, rsp_evalid_in;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_entry;
   logic [IDX_W-1:0]       rd_addr;
   logic [ENTRY_W-1:0]     rd_data;
   entry_type              ent;

   logic                   full;
   logic                   occupied;
   logic                   tag_hit;
   logic                   last_occ;
   logic                   find_done;
   logic                   victim;
   logic                   scan_done;

   ipt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_FRAMES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // scan decode on the word returned for chk_ptr
   always_comb begin
      ent       = entry_type'(rd_data);
      full      = (alloc_ff == FULL_CNT);
      occupied  = CNT_W'(chk_ptr_ff) < alloc_ff;
      tag_hit   = occupied && (ent.page == vpage_ff) && (ent.pid == pid_ff);
      last_occ  = (CNT_W'(chk_ptr_ff) + CNT_W'(1)) >= alloc_ff;
      find_done = chk_vld_ff && (tag_hit || last_occ);
      victim    = chk_vld_ff && !ent.use_flag;
      scan_done = (op_ff == OP_FIND) ? find_done : victim;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (scan_ptr_ff == LAST_IDX) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (req_op == OP_FIND || (req_op == OP_REQUEST && full)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RMW_RD;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_IDLE;
         end
         ST_RMW_RD: state_in = ST_RMW_WR;
         ST_RMW_WR: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath, store access and response word
   always_comb begin
      op_in          = op_ff;
      vpage_in       = vpage_ff;
      pid_in         = pid_ff;
      fidx_in        = fidx_ff;
      nvalid_in      = nvalid_ff;
      nuse_in        = nuse_ff;
      ndirty_in      = ndirty_ff;
      in_range_in    = in_range_ff;
      scan_ptr_in    = scan_ptr_ff;
      chk_ptr_in     = chk_ptr_ff;
      chk_vld_in     = 1'b0;
      alloc_in       = alloc_ff;
      hand_in        = hand_ff;
      rsp_valid_in   = 1'b0;
      rsp_found_in   = rsp_found_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_wb_in      = rsp_wb_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_epage_in   = rsp_epage_ff;
      rsp_evalid_in  = rsp_evalid_ff;
      wr_en          = 1'b0;
      wr_addr        = scan_ptr_ff;
      wr_entry       = ent;
      rd_addr        = scan_ptr_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_entry    = '0;
            scan_ptr_in = next_idx(scan_ptr_ff);
         end
         ST_IDLE: begin
            if (start) begin
               op_in       = req_op;
               vpage_in    = req_virtual_page;
               pid_in      = req_process_id;
               fidx_in     = req_frame_index;
               nvalid_in   = req_new_valid;
               nuse_in     = req_new_use;
               ndirty_in   = req_new_dirty;
               in_range_in = int'(req_frame_index) < NUM_FRAMES;
               case (req_op)
                  OP_FIND:    scan_ptr_in = '0;
                  OP_REQUEST: scan_ptr_in = full ? hand_ff : alloc_ff[IDX_W-1:0];
                  default:    scan_ptr_in = IDX_W'(req_frame_index);
               endcase
            end
         end
         ST_SCAN: begin
            // read one ahead; a swept entry is written back in the same cycle as its check
            scan_ptr_in  = next_idx(scan_ptr_ff);
            chk_ptr_in   = scan_ptr_ff;
            chk_vld_in   = !scan_done;
            wr_addr      = chk_ptr_ff;
            rsp_valid_in = scan_done;
            if (op_ff == OP_FIND) begin
               rsp_found_in   = tag_hit;
               rsp_frame_in   = tag_hit ? FRAME_W'(chk_ptr_ff) : '0;
               rsp_wb_in      = 1'b0;
               rsp_evicted_in = '0;
               rsp_epage_in   = '0;
               rsp_evalid_in  = 1'b0;
            end else if (chk_vld_ff) begin
               wr_en = 1'b1;
               if (ent.use_flag) begin
                  wr_entry.use_flag = 1'b0;
               end else begin
                  wr_entry.page = vpage_ff;
                  wr_entry.pid  = pid_ff;
                  if (ent.dirty) begin
                     wr_entry.valid    = 1'b0;
                     wr_entry.use_flag = 1'b0;
                     wr_entry.dirty    = 1'b0;
                  end
                  hand_in        = next_idx(chk_ptr_ff);
                  rsp_found_in   = 1'b1;
                  rsp_frame_in   = FRAME_W'(chk_ptr_ff);
                  rsp_wb_in      = ent.dirty;
                  rsp_evicted_in = ent.dirty ? ent.page : '0;
                  rsp_epage_in   = '0;
                  rsp_evalid_in  = 1'b0;
               end
            end
         end
         ST_RMW_RD: begin
            rd_addr = scan_ptr_ff;
         end
         ST_RMW_WR: begin
            rsp_valid_in   = 1'b1;
            rsp_found_in   = 1'b1;
            rsp_wb_in      = 1'b0;
            rsp_evicted_in = '0;
            rsp_epage_in   = '0;
            rsp_evalid_in  = 1'b0;
            rsp_frame_in   = fidx_ff;
            case (op_ff)
               OP_REQUEST: begin
                  wr_en         = 1'b1;
                  wr_entry.page = vpage_ff;
                  wr_entry.pid  = pid_ff;
                  alloc_in      = alloc_ff + 1'b1;
                  rsp_frame_in  = FRAME_W'(scan_ptr_ff);
               end
               OP_SAVE: begin
                  wr_en             = in_range_ff;
                  wr_entry.valid    = nvalid_ff;
                  wr_entry.use_flag = nuse_ff;
                  wr_entry.dirty    = ndirty_ff;
               end
               OP_MOVE: begin
                  // unoccupied frames still hold the cleared page
                  wr_en          = in_range_ff;
                  wr_entry.valid = 1'b1;
                  rsp_epage_in   = in_range_ff ? ent.page : '0;
                  rsp_evalid_in  = in_range_ff;
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ptr_ff  <= '0;
         chk_ptr_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         alloc_ff     <= '0;
         hand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= OP_FIND;
      end else begin
         state_ff     <= state_in;
         scan_ptr_ff  <= scan_ptr_in;
         chk_ptr_ff   <= chk_ptr_in;
         chk_vld_ff   <= chk_vld_in;
         alloc_ff     <= alloc_in;
         hand_ff      <= hand_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      vpage_ff       <= vpage_in;
      pid_ff         <= pid_in;
      fidx_ff        <= fidx_in;
      nvalid_ff      <= nvalid_in;
      nuse_ff        <= nuse_in;
      ndirty_ff      <= ndirty_in;
      in_range_ff    <= in_range_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_wb_ff      <= rsp_wb_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_epage_ff   <= rsp_epage_in;
      rsp_evalid_ff  <= rsp_evalid_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_frame_out    = rsp_frame_ff;
   assign rsp_write_back   = rsp_wb_ff;
   assign rsp_evicted_page = rsp_evicted_ff;
   assign rsp_entry_page   = rsp_epage_ff;
   assign rsp_entry_valid  = rsp_evalid_ff;

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      alloc_ff <= FULL_CNT)
      else $error("allocation count beyond frame count");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not occupy the block");

   a_sweep_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && op_ff == OP_REQUEST) |-> full)
      else $error("clock sweep while free frames remain");

   a_wb_request: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_wb_ff) |-> (op_ff == OP_REQUEST))
      else $error("write-back reported for an operation other than request");

   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("response during clearing pass");

endmodule

// ===== test/inverted_page_table_clock_test.sv =====
// Self-checking bench for the inverted page table with clock replacement:
// random and directed commands, a cycle-free predictor and an in-order word check.
// Depends on ipt_pkg and inverted_page_table_clock.
`timescale 1ns / 1ps

module inverted_page_table_clock_test;
   import ipt_pkg::*;

   localparam int NUM_FRAMES = 32;
   localparam int VPAGE_BITS = 20;
   localparam int PID_BITS   = 8;
   localparam int RANDOM_WORDS = 1950;

   typedef struct {
      op_type                op;
      logic [VPAGE_BITS-1:0] page;
      logic [PID_BITS-1:0]   pid;
      logic [FRAME_W-1:0]    frame;
      logic                  set_valid;
      logic                  set_use;
      logic                  set_dirty;
   } table_cmd_type;

   typedef struct {
      logic                  found;
      logic [FRAME_W-1:0]    frame;
      logic                  write_back;
      logic [VPAGE_BITS-1:0] evicted_page;
      logic [VPAGE_BITS-1:0] entry_page;
      logic                  entry_valid;
   } table_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   op_type                req_op = OP_FIND;
   logic [VPAGE_BITS-1:0] req_virtual_page = '0;
   logic [PID_BITS-1:0]   req_process_id = '0;
   logic [FRAME_W-1:0]    req_frame_index = '0;
   logic                  req_new_valid = 1'b0;
   logic                  req_new_use = 1'b0;
   logic                  req_new_dirty = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_found;
   logic [FRAME_W-1:0]    rsp_frame_out;
   logic                  rsp_write_back;
   logic [VPAGE_BITS-1:0] rsp_evicted_page;
   logic [VPAGE_BITS-1:0] rsp_entry_page;
   logic                  rsp_entry_valid;

   inverted_page_table_clock #(
      .NUM_FRAMES(NUM_FRAMES),
      .VPAGE_BITS(VPAGE_BITS),
      .PID_BITS(PID_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_virtual_page(req_virtual_page),
      .req_process_id(req_process_id),
      .req_frame_index(req_frame_index),
      .req_new_valid(req_new_valid),
      .req_new_use(req_new_use),
      .req_new_dirty(req_new_dirty),
      .rsp_valid(rsp_valid),
      .rsp_found(rsp_found),
      .rsp_frame_out(rsp_frame_out),
      .rsp_write_back(rsp_write_back),
      .rsp_evicted_page(rsp_evicted_page),
      .rsp_entry_page(rsp_entry_page),
      .rsp_entry_valid(rsp_entry_valid)
   );

   always #2 clock = ~clock;

   // shadow copy of the frame table
   logic [VPAGE_BITS-1:0] shadow_page [NUM_FRAMES];
   logic [PID_BITS-1:0]   shadow_pid  [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] shadow_occupied = '0;
   logic [NUM_FRAMES-1:0] shadow_valid = '0;
   logic [NUM_FRAMES-1:0] shadow_use = '0;
   logic [NUM_FRAMES-1:0] shadow_dirty = '0;
   logic [NUM_FRAMES-1:0] shadow_free = '1;
   logic [FRAME_W-1:0]    shadow_hand = '0;

   table_cmd_type   pending_cmds[$];
   table_reply_type expected_replies[$];
   table_cmd_type   current_cmd;

   int op_counts[4] = '{default: 0};
   int find_hits = 0;
   int sweep_count = 0;
   int evict_count = 0;
   int accepted_count = 0;
   int checked_count = 0;
   int mismatch_count = 0;
   int idle_left = 0;
   logic took;

   logic [VPAGE_BITS-1:0] page_pool [12];
   logic [PID_BITS-1:0]   pid_pool [3];

   function automatic table_reply_type apply_table_op(table_cmd_type c);
      table_reply_type r;
      logic [FRAME_W-1:0] f;
      logic got;
      int n;
      r = '{found: 1'b1, frame: '0, write_back: 1'b0, evicted_page: '0,
            entry_page: '0, entry_valid: 1'b0};
      op_counts[c.op]++;
      case (c.op)
         OP_FIND: begin
            r.found = 1'b0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
               if (!r.found && shadow_occupied[i] && shadow_page[i] == c.page &&
                   shadow_pid[i] == c.pid) begin
                  r.found = 1'b1;
                  r.frame = FRAME_W'(i);
               end
            end
            if (r.found) find_hits++;
         end
         OP_REQUEST: begin
            got = 1'b0;
            f = '0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
               if (!got && shadow_free[i]) begin
                  shadow_free[i] = 1'b0;
                  f = FRAME_W'(i);
                  got = 1'b1;
               end
            end
            if (!got) begin
               // clock sweep: clear use bits up to the first entry with use clear
               sweep_count++;
               f = shadow_hand;
               for (n = 0; n < 2 * NUM_FRAMES; n++) begin
                  if (!shadow_use[f]) break;
                  shadow_use[f] = 1'b0;
                  f = f + 1'b1;
               end
               shadow_hand = f + 1'b1;
               if (shadow_dirty[f]) begin
                  evict_count++;
                  r.write_back = 1'b1;
                  r.evicted_page = shadow_page[f];
                  shadow_valid[f] = 1'b0;
                  shadow_use[f] = 1'b0;
                  shadow_dirty[f] = 1'b0;
               end
            end
            shadow_occupied[f] = 1'b1;
            shadow_page[f] = c.page;
            shadow_pid[f] = c.pid;
            r.frame = f;
         end
         OP_SAVE: begin
            r.frame = c.frame;
            shadow_valid[c.frame] = c.set_valid;
            shadow_use[c.frame] = c.set_use;
            shadow_dirty[c.frame] = c.set_dirty;
         end
         default: begin
            r.frame = c.frame;
            shadow_valid[c.frame] = 1'b1;
            r.entry_page = shadow_occupied[c.frame] ? shadow_page[c.frame] : '0;
            r.entry_valid = 1'b1;
         end
      endcase
      return r;
   endfunction

   function automatic table_cmd_type make_cmd(op_type op, logic [VPAGE_BITS-1:0] page,
                                         logic [PID_BITS-1:0] pid, logic [FRAME_W-1:0] frame,
                                         logic v, logic u, logic d);
      table_cmd_type c;
      c.op = op;
      c.page = page;
      c.pid = pid;
      c.frame = frame;
      c.set_valid = v;
      c.set_use = u;
      c.set_dirty = d;
      return c;
   endfunction

   // mostly pooled values so that finds hit and pairs repeat
   function automatic logic [VPAGE_BITS-1:0] pick_page();
      if ($urandom_range(0, 9) < 7) return page_pool[$urandom_range(0, 11)];
      return VPAGE_BITS'($urandom);
   endfunction

   function automatic logic [PID_BITS-1:0] pick_pid();
      if ($urandom_range(0, 9) < 7) return pid_pool[$urandom_range(0, 2)];
      return PID_BITS'($urandom);
   endfunction

   function automatic table_cmd_type random_cmd();
      return make_cmd(op_type'($urandom_range(0, 3)), pick_page(), pick_pid(),
                      FRAME_W'($urandom_range(0, NUM_FRAMES - 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
   endfunction

   task automatic flag_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 40) $display("mismatch: %s", what);
   endtask

   // driver: start held high until the word is taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
      end else begin
         took = start && !busy;
         if (took) begin
            expected_replies.push_back(apply_table_op(current_cmd));
            accepted_count++;
         end
         if (took || !start) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               current_cmd = pending_cmds.pop_front();
               start <= 1'b1;
               req_op <= current_cmd.op;
               req_virtual_page <= current_cmd.page;
               req_process_id <= current_cmd.pid;
               req_frame_index <= current_cmd.frame;
               req_new_valid <= current_cmd.set_valid;
               req_new_use <= current_cmd.set_use;
               req_new_dirty <= current_cmd.set_dirty;
               // no gaps in the last stretch
               if (pending_cmds.size() > 150 && $urandom_range(0, 5) == 0)
                  idle_left = $urandom_range(1, 9);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobed word is compared with the oldest expectation
   always @(posedge clock) begin
      table_reply_type want;
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            flag_mismatch($sformatf("unexpected word, frame_out=%0d", rsp_frame_out));
         end else begin
            want = expected_replies.pop_front();
            checked_count++;
            if (rsp_found !== want.found || rsp_frame_out !== want.frame ||
                rsp_write_back !== want.write_back ||
                rsp_evicted_page !== want.evicted_page ||
                rsp_entry_page !== want.entry_page ||
                rsp_entry_valid !== want.entry_valid)
               flag_mismatch($sformatf(
                  "word %0d got %b/%0d/%b/%h/%h/%b want %b/%0d/%b/%h/%h/%b",
                  checked_count, rsp_found, rsp_frame_out, rsp_write_back,
                  rsp_evicted_page, rsp_entry_page, rsp_entry_valid, want.found,
                  want.frame, want.write_back, want.evicted_page, want.entry_page,
                  want.entry_valid));
         end
      end
   end

   initial begin
      logic [VPAGE_BITS-1:0] pg;
      logic [PID_BITS-1:0] id;
      int made;
      int kind;

      page_pool[0] = '0;
      page_pool[1] = '1;
      for (int i = 2; i < 12; i++) page_pool[i] = VPAGE_BITS'($urandom);
      pid_pool[0] = '0;
      pid_pool[1] = '1;
      pid_pool[2] = PID_BITS'($urandom);

      // directed: empty-table cases, extremes, duplicate pairs
      pending_cmds.push_back(make_cmd(OP_FIND, '0, '0, '0, 1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_MOVE, '0, '0, 5'd31, 1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SAVE, '0, '0, 5'd0, 1'b1, 1'b1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_REQUEST, '1, '1, '0, 1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_REQUEST, '0, '0, '1, 1'b1, 1'b1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_FIND, '1, '1, '0, 1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_FIND, '1, '0, '0, 1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_FIND, '0, '0, '0, 1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_MOVE, '0, '0, 5'd0, 1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SAVE, '1, '1, 5'd31, 1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SAVE, '0, '0, 5'd1, 1'b1, 1'b0, 1'b1));
      pending_cmds.push_back(make_cmd(OP_REQUEST, '0, '0, '0, 1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_FIND, '0, '0, '0, 1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_MOVE, '1, '1, 5'd2, 1'b1, 1'b1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_SAVE, '1, '1, 5'd16, 1'b1, 1'b1, 1'b0));

      made = 0;
      while (made < RANDOM_WORDS) begin
         kind = $urandom_range(0, 99);
         if (kind < 3) begin
            // all use bits set: a sweep on a full table takes a whole pass
            for (int f = 0; f < NUM_FRAMES; f++)
               pending_cmds.push_back(make_cmd(OP_SAVE, pick_page(), pick_pid(),
                  FRAME_W'(f), 1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1))));
            pending_cmds.push_back(make_cmd(OP_REQUEST, pick_page(), pick_pid(), '0,
                                            1'b0, 1'b0, 1'b0));
            made += NUM_FRAMES + 1;
         end else if (kind < 25) begin
            // map a pair, look it up, then touch a frame
            pg = pick_page();
            id = pick_pid();
            pending_cmds.push_back(make_cmd(OP_REQUEST, pg, id, '0, 1'b0, 1'b0, 1'b0));
            pending_cmds.push_back(make_cmd(OP_FIND, pg, id, '0, 1'b0, 1'b0, 1'b0));
            pending_cmds.push_back(make_cmd($urandom_range(0, 1) ? OP_SAVE : OP_MOVE,
               pg, id, FRAME_W'($urandom_range(0, NUM_FRAMES - 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1))));
            made += 3;
         end else begin
            pending_cmds.push_back(random_cmd());
            made++;
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || start) @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (NUM_FRAMES + 8) @(posedge clock);

      if (expected_replies.size() != 0)
         flag_mismatch($sformatf("%0d words never arrived", expected_replies.size()));
      $display("%0d commands: %0d find (%0d hits), %0d request, %0d save, %0d move",
               accepted_count, op_counts[OP_FIND], find_hits, op_counts[OP_REQUEST],
               op_counts[OP_SAVE], op_counts[OP_MOVE]);
      $display("%0d clock sweeps, %0d dirty evictions, %0d words checked",
               sweep_count, evict_count, checked_count);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout after %0d commands", accepted_count);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
